// ===== hdl/fpdp_pkg.sv =====
`timescale 1ns / 1ps

package fpdp_pkg;

    localparam int TICK_W   = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W    = $clog2(TICK_W);

    // tdata of the request channel: now, phase, period, generation
    localparam int IN_DATA_W = 4 * TICK_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 1'b1;

    localparam logic [TICK_W-1:0] MIN_GAP_RESET    = 64'd250000000;
    localparam logic [TICK_W-1:0] MAX_PERIOD_RESET = 64'd1000000000;
    localparam logic [TICK_W-1:0] TICK_MAX         = {TICK_W{1'b1}};

    typedef struct packed {
        logic load_in;
        logic prep;
        logic limit;
        logic disc;
        logic div_start;
        logic grid;
        logic steady;
        logic clamp;
        logic clear;
        logic load_out;
    } fpdp_cmd_t;

    typedef struct packed {
        logic bypass;
        logic disc;
        logic anchor_gt;
        logic div_busy;
    } fpdp_status_t;

    // Saturating unsigned add.
    function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                  input logic [TICK_W-1:0] b);
        logic [TICK_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
    endfunction

endpackage

// ===== hdl/fpdp_rem.sv =====
`timescale 1ns / 1ps

module fpdp_rem
    import fpdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [TICK_W-1:0] divisor,
    output logic              busy,
    output logic [TICK_W-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] dvd_reg, dvd_next;
    logic [TICK_W-1:0] dsr_reg, dsr_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [TICK_W:0]   rem_sh;

    // Restoring remainder: one dividend bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, dvd_reg[TICK_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TICK_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dsr_reg})
                rem_next = TICK_W'(rem_sh - {1'b0, dsr_reg});
            else
                rem_next = rem_sh[TICK_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TICK_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/fpdp_datapath.sv =====
`timescale 1ns / 1ps

module fpdp_datapath
    import fpdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpdp_cmd_t            cmd,
    output fpdp_status_t         status,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic                 in_active,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    output logic [TICK_W-1:0]    out_data
);

    // configuration
    logic [TICK_W-1:0] min_cfg_reg, min_cfg_next;
    logic [TICK_W-1:0] max_cfg_reg, max_cfg_next;

    // pacing state
    logic              started_reg, started_next;
    logic [TICK_W-1:0] last_gen_reg, last_gen_next;
    logic [TICK_W-1:0] last_base_reg, last_base_next;
    logic [TICK_W-1:0] deadline_reg, deadline_next;

    // request and working values
    logic [TICK_W-1:0] now_reg, now_next;
    logic [TICK_W-1:0] phase_reg, phase_next;
    logic [TICK_W-1:0] period_reg, period_next;
    logic [TICK_W-1:0] gen_reg, gen_next;
    logic              active_reg, active_next;
    logic [TICK_W-1:0] cap_reg, cap_next;
    logic [TICK_W-1:0] min_gap_reg, min_gap_next;
    logic [TICK_W-1:0] limit_reg, limit_next;
    logic              disc_reg, disc_next;
    logic              anchor_gt_reg, anchor_gt_next;
    logic [TICK_W-1:0] anchor_reg, anchor_next;
    logic [TICK_W-1:0] diff_reg, diff_next;
    logic [TICK_W-1:0] wait_reg, wait_next;
    logic [TICK_W-1:0] cand_reg, cand_next;
    logic [TICK_W-1:0] out_reg, out_next;

    logic [TICK_W-1:0] period_x4;
    logic              keep_phase;
    logic [TICK_W-1:0] base;
    logic [TICK_W-1:0] rem;
    logic              rem_busy;

    fpdp_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (diff_reg),
        .divisor   (period_reg),
        .busy      (rem_busy),
        .remainder (rem)
    );

    always_comb
    begin
        min_cfg_next   = min_cfg_reg;
        max_cfg_next   = max_cfg_reg;
        started_next   = started_reg;
        last_gen_next  = last_gen_reg;
        last_base_next = last_base_reg;
        deadline_next  = deadline_reg;
        now_next       = now_reg;
        phase_next     = phase_reg;
        period_next    = period_reg;
        gen_next       = gen_reg;
        active_next    = active_reg;
        cap_next       = cap_reg;
        min_gap_next   = min_gap_reg;
        limit_next     = limit_reg;
        disc_next      = disc_reg;
        anchor_gt_next = anchor_gt_reg;
        anchor_next    = anchor_reg;
        diff_next      = diff_reg;
        wait_next      = wait_reg;
        cand_next      = cand_reg;
        out_next       = out_reg;

        period_x4  = (period_reg[TICK_W-1:TICK_W-2] != 2'b00) ? TICK_MAX
                   : {period_reg[TICK_W-3:0], 2'b00};
        keep_phase = (phase_reg != '0)
                  && !((phase_reg > now_reg) && ((phase_reg - now_reg) > limit_reg))
                  && !((phase_reg <= now_reg) && ((now_reg - phase_reg) > limit_reg));
        base       = (wait_reg != '0) ? wait_reg : now_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_GAP:    min_cfg_next = cfg_data;
                CFG_MAX_PERIOD: max_cfg_next = cfg_data;
                default:        ;
            endcase
        end

        if (cmd.load_in)
        begin
            now_next    = in_data[TICK_W-1:0];
            phase_next  = in_data[2*TICK_W-1:TICK_W];
            period_next = in_data[3*TICK_W-1:2*TICK_W];
            gen_next    = in_data[4*TICK_W-1:3*TICK_W];
            active_next = in_active;
        end

        // zero registers mean "smallest gap" and "no cap"; cap the period
        if (cmd.prep)
        begin
            cap_next     = (max_cfg_reg != '0) ? max_cfg_reg : TICK_MAX;
            min_gap_next = (min_cfg_reg != '0) ? min_cfg_reg : TICK_W'(1);
            if (max_cfg_reg != '0 && period_reg > max_cfg_reg)
                period_next = max_cfg_reg;
        end

        if (cmd.limit)
            limit_next = (period_x4 < min_gap_reg) ? min_gap_reg : period_x4;

        if (cmd.disc)
        begin
            disc_next = !started_reg || (last_gen_reg != gen_reg)
                     || (now_reg < last_base_reg)
                     || ((last_base_reg != '0) && ((now_reg - last_base_reg) > limit_reg));
            anchor_next    = keep_phase ? phase_reg : now_reg;
            anchor_gt_next = keep_phase && (phase_reg > now_reg);
            diff_next      = keep_phase ? (now_reg - phase_reg) : '0;
        end

        // first grid point after now: anchor if ahead, else now - ((now - anchor) mod period) + period
        if (cmd.grid)
        begin
            wait_next = '0;
            cand_next = anchor_gt_reg ? anchor_reg : sat_add(now_reg - rem, period_reg);
        end

        if (cmd.steady)
        begin
            if ((deadline_reg > now_reg) && ((deadline_reg - now_reg) <= cap_reg))
            begin
                wait_next = deadline_reg;
                cand_next = sat_add(deadline_reg, period_reg);
            end
            else
            begin
                wait_next = '0;
                cand_next = sat_add(now_reg, period_reg);
            end
        end

        if (cmd.clamp)
        begin
            if ((cand_reg <= base) || ((cand_reg - base) > cap_reg))
                deadline_next = sat_add(base, cap_reg);
            else
                deadline_next = cand_reg;
            last_base_next = base;
            last_gen_next  = gen_reg;
            started_next   = 1'b1;
        end

        if (cmd.clear)
        begin
            wait_next      = '0;
            started_next   = 1'b0;
            last_gen_next  = '0;
            last_base_next = '0;
            deadline_next  = '0;
        end

        if (cmd.load_out)
            out_next = wait_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cfg_reg   <= MIN_GAP_RESET;
            max_cfg_reg   <= MAX_PERIOD_RESET;
            started_reg   <= 1'b0;
            last_gen_reg  <= '0;
            last_base_reg <= '0;
            deadline_reg  <= '0;
        end
        else
        begin
            min_cfg_reg   <= min_cfg_next;
            max_cfg_reg   <= max_cfg_next;
            started_reg   <= started_next;
            last_gen_reg  <= last_gen_next;
            last_base_reg <= last_base_next;
            deadline_reg  <= deadline_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        phase_reg     <= phase_next;
        period_reg    <= period_next;
        gen_reg       <= gen_next;
        active_reg    <= active_next;
        cap_reg       <= cap_next;
        min_gap_reg   <= min_gap_next;
        limit_reg     <= limit_next;
        disc_reg      <= disc_next;
        anchor_gt_reg <= anchor_gt_next;
        anchor_reg    <= anchor_next;
        diff_reg      <= diff_next;
        wait_reg      <= wait_next;
        cand_reg      <= cand_next;
        out_reg       <= out_next;
    end

    assign status.bypass    = !active_reg || (period_reg == '0);
    assign status.disc      = disc_reg;
    assign status.anchor_gt = anchor_gt_reg;
    assign status.div_busy  = rem_busy;
    assign out_data         = out_reg;

endmodule

// ===== hdl/fpdp_ctrl.sv =====
`timescale 1ns / 1ps

module fpdp_ctrl
    import fpdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  fpdp_status_t status,
    output fpdp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_PREP   = 11'b000_0000_0010,
        ST_LIMIT  = 11'b000_0000_0100,
        ST_DISC   = 11'b000_0000_1000,
        ST_ROUTE  = 11'b000_0001_0000,
        ST_DIV    = 11'b000_0010_0000,
        ST_GRID   = 11'b000_0100_0000,
        ST_STEADY = 11'b000_1000_0000,
        ST_CLAMP  = 11'b001_0000_0000,
        ST_CLEAR  = 11'b010_0000_0000,
        ST_DONE   = 11'b100_0000_0000
    } fpdp_state_t;

    fpdp_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.bypass ? ST_CLEAR : ST_LIMIT;
            end
            ST_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = ST_DISC;
            end
            ST_DISC:
            begin
                cmd.disc   = 1'b1;
                state_next = ST_ROUTE;
            end
            ST_ROUTE:
            begin
                if (!status.disc)
                    state_next = ST_STEADY;
                else if (status.anchor_gt)
                    state_next = ST_GRID;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = ST_GRID;
            end
            ST_GRID:
            begin
                cmd.grid   = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_STEADY:
            begin
                cmd.steady = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/frame_present_deadline_pacer.sv =====
`timescale 1ns / 1ps
// Frame present deadline pacer.
// Request channel (s_axis_*): one item per frame present carrying the current
// time, the vsync phase anchor, the frame period and the generation tag in
// tdata, and the active flag in tuser. Result channel (m_axis_*): one item per
// request, the absolute time to wait until before presenting (0 = present now).
// Configuration: cfg_we / cfg_index / cfg_data write the minimum discontinuity
// gap (index 0) and the period cap (index 1); write them only while idle.
// Steps: accept, prep, then clear and done for an inactive request or a zero
// period; else limit, disc, route, then steady in steady state, grid when a
// discontinuity realigns to an anchor ahead of now, or div (the bit-serial
// remainder unit) and grid when the grid point behind now is to be found;
// then clamp and done. One request is in work at a time; idle takes the next.
// Reset: configuration returns to 250000000 / 1000000000 ticks, pacing state
// clears, both channels go idle.
// A stalled receiver holds the result in the output register; the next request
// is still taken and worked on, and its result waits until the slot frees.
module frame_present_deadline_pacer
    import fpdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // now_ticks [63:0], phase_ticks [127:64], period_ticks [191:128],
    // generation_tag [255:192]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // active [0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // wait_until_ticks [63:0]
    output logic [TICK_W-1:0]    m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    fpdp_cmd_t    cmd;
    fpdp_status_t status;

    // Sequence the steps of one request.
    fpdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold configuration, pacing state and the deadline arithmetic.
    fpdp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_active (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

endmodule
